FILE: hw/rtl/pll_fraction_retune_writer_defines.svh
// Assertion macros for the PLL fraction retune writer.
// Included by the top level; no other dependencies.
`ifndef PLL_FRACTION_RETUNE_WRITER_DEFINES_SVH
`define PLL_FRACTION_RETUNE_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, off while reset is held
`define PRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define PRW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRW_ASSERT(lbl, prop, msg)
`define PRW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/prw_pkg.sv
// Shared types, constants and the microcode table of the retune writer.
// No dependencies.
package prw_pkg;

  localparam int OFFSET_W   = 16;
  localparam int FBASE_W    = 26;
  localparam int IBASE_W    = 16;
  localparam int ODIV_W     = 8;
  localparam int XTAL_W     = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;
  localparam int PROD_W     = ODIV_W + OFFSET_W;
  localparam int FRAC_SHIFT = 26;
  localparam int DIV_STEPS  = PROD_W + FRAC_SHIFT;
  localparam int CNT_W      = 6;
  localparam int QUO_W      = 32;
  localparam int FRAC_W     = 32;
  localparam int P2_BITS    = 19;
  localparam int PC_W       = 4;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRACTION_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGER_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_DIVIDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL_HZ     = 3'd3;

  localparam logic [XTAL_W-1:0] CRYSTAL_RESET = 27'd27003380;
  localparam logic [BYTE_W-1:0] ADDR_FULL     = 8'd37;
  localparam logic [BYTE_W-1:0] ADDR_SHORT    = 8'd38;
  localparam logic [4:0]        P2_TOP_MARK   = 5'b10000;

  // datapath operations
  localparam logic [2:0] OP_WAIT = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_DIV  = 3'd2;
  localparam logic [2:0] OP_FRAC = 3'd3;
  localparam logic [2:0] OP_P1   = 3'd4;
  localparam logic [2:0] OP_EMIT = 3'd5;

  // jump conditions
  localparam logic [1:0] COND_NONE   = 2'd0;
  localparam logic [1:0] COND_ALWAYS = 2'd1;
  localparam logic [1:0] COND_CNT_NZ = 2'd2;
  localparam logic [1:0] COND_SHORT  = 2'd3;

  // byte selects
  localparam logic [2:0] SEL_ADDR   = 3'd0;
  localparam logic [2:0] SEL_P1_MID = 3'd1;
  localparam logic [2:0] SEL_P1_LO  = 3'd2;
  localparam logic [2:0] SEL_P2_HI  = 3'd3;
  localparam logic [2:0] SEL_P2_MID = 3'd4;
  localparam logic [2:0] SEL_P2_LO  = 3'd5;

  // program steps
  localparam logic [PC_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [PC_W-1:0] STEP_MUL  = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIV  = 4'd2;
  localparam logic [PC_W-1:0] STEP_FRAC = 4'd3;
  localparam logic [PC_W-1:0] STEP_P1   = 4'd4;
  localparam logic [PC_W-1:0] STEP_ADDR = 4'd5;
  localparam logic [PC_W-1:0] STEP_B3   = 4'd6;
  localparam logic [PC_W-1:0] STEP_B4   = 4'd7;
  localparam logic [PC_W-1:0] STEP_B5   = 4'd8;
  localparam logic [PC_W-1:0] STEP_B6   = 4'd9;
  localparam logic [PC_W-1:0] STEP_B7   = 4'd10;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      sel;
    logic            first;
    logic            last;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_WAIT, sel: SEL_ADDR, first: 1'b0, last: 1'b0,
          cond: COND_ALWAYS, target: STEP_WAIT};
    case (pc)
      STEP_WAIT: w = '{OP_WAIT, SEL_ADDR,   1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_MUL:  w = '{OP_MUL,  SEL_ADDR,   1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_DIV:  w = '{OP_DIV,  SEL_ADDR,   1'b0, 1'b0, COND_CNT_NZ, STEP_DIV};
      STEP_FRAC: w = '{OP_FRAC, SEL_ADDR,   1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_P1:   w = '{OP_P1,   SEL_ADDR,   1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_ADDR: w = '{OP_EMIT, SEL_ADDR,   1'b1, 1'b0, COND_SHORT,  STEP_B4};
      STEP_B3:   w = '{OP_EMIT, SEL_P1_MID, 1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_B4:   w = '{OP_EMIT, SEL_P1_LO,  1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_B5:   w = '{OP_EMIT, SEL_P2_HI,  1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_B6:   w = '{OP_EMIT, SEL_P2_MID, 1'b0, 1'b0, COND_NONE,   STEP_WAIT};
      STEP_B7:   w = '{OP_EMIT, SEL_P2_LO,  1'b0, 1'b1, COND_ALWAYS, STEP_WAIT};
      default:   w = '{OP_WAIT, SEL_ADDR,   1'b0, 1'b0, COND_ALWAYS, STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/prw_div.sv
// Bit-serial restoring divider: scaled offset product by crystal frequency.
// Depends on prw_pkg; stepped by the sequencer in the top level.
module prw_div
  import prw_pkg::*;
(
  input  logic              clk,
  input  div_ctrl_t         ctrl,
  input  logic [PROD_W-1:0] product,
  input  logic [XTAL_W-1:0] divisor,
  output logic [QUO_W-1:0]  quotient
);

  logic [PROD_W-1:0] num_r, num_nxt;
  logic [XTAL_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [XTAL_W:0]   trial;
  logic [XTAL_W+1:0] diff;
  logic              ge;

  // numerator is product followed by FRAC_SHIFT zeros: shift zeros in
  assign trial = {rem_r, num_r[PROD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign ge    = ~diff[XTAL_W+1];

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (ctrl.load) begin
      num_nxt = product;
      rem_nxt = '0;
      quo_nxt = '0;
    end else if (ctrl.step) begin
      num_nxt = {num_r[PROD_W-2:0], 1'b0};
      rem_nxt = ge ? diff[XTAL_W-1:0] : trial[XTAL_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

FILE: hw/rtl/pll_fraction_retune_writer.sv
// Top level of the PLL fraction retune writer: microcoded sequencer,
// datapath and output register. Depends on prw_pkg, prw_div and the defines.
//
// Usage: each request on the in_ channel carries a signed offset in hertz.
// The block scales it by the output divider and 2^26, divides by the crystal
// frequency, adds it to the fraction base and streams one register write on
// the out_ channel: an address byte (first, tuser[0]), then four or five data
// bytes, the final one with tlast. tuser[1] marks a short write, in which the
// unchanged P1 middle byte is skipped.
// The bit-serial divider runs 50 steps per request. in_tready is high only in
// the wait step of the program, so one request is in flight at a time.
// A stall on out_ holds the sequencer in its emit step; a byte waits in the
// output register while the next one is prepared.
// Reset returns the program to its wait step, drops out_tvalid, loads the
// register defaults and clears the stored P1 middle byte. Configuration
// writes are always taken (cfg_ready is high) and must come while idle.
`include "pll_fraction_retune_writer_defines.svh"

module pll_fraction_retune_writer
  import prw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [OFFSET_W-1:0]   in_tdata,   // [15:0] offset_hz
  // result bytes
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] write_byte
  output logic [1:0]            out_tuser,  // [0] first_byte, [1] short_write
  output logic                  out_tlast   // last_byte
);

  logic [FBASE_W-1:0] fbase_r;
  logic [IBASE_W-1:0] ibase_r;
  logic [ODIV_W-1:0]  odiv_r;
  logic [XTAL_W-1:0]  xtal_r;

  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OFFSET_W-1:0] mag_r;
  logic                neg_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [IBASE_W-1:0]  p1_r, p1_sum;
  logic [BYTE_W-1:0]   last_mid_r;
  logic                short_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_first_r, out_last_r, out_short_r;

  ctrl_t             cw;
  div_ctrl_t         div_ctrl;
  logic [PROD_W-1:0] product;
  logic [QUO_W-1:0]  quotient;
  logic [QUO_W-1:0]  term;
  logic              slot_free;
  logic              hold;
  logic              take_jump;
  logic [BYTE_W-1:0] byte_sel;

  assign cw        = rom_word(pc_r);
  assign slot_free = ~out_valid_r | out_tready;
  assign in_tready = (cw.op == OP_WAIT);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbase_r <= '0;
      ibase_r <= '0;
      odiv_r  <= '0;
      xtal_r  <= CRYSTAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRACTION_BASE:  fbase_r <= cfg_data[FBASE_W-1:0];
        REG_INTEGER_BASE:   ibase_r <= cfg_data[IBASE_W-1:0];
        REG_OUTPUT_DIVIDER: odiv_r  <= cfg_data[ODIV_W-1:0];
        REG_CRYSTAL_HZ:     xtal_r  <= cfg_data[XTAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign div_ctrl.load = (cw.op == OP_MUL);
  assign div_ctrl.step = (cw.op == OP_DIV);
  assign product       = PROD_W'(odiv_r) * PROD_W'(mag_r);

  prw_div u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .product  (product),
    .divisor  (xtal_r),
    .quotient (quotient)
  );

  // zero crystal gives no offset term
  assign term   = (xtal_r == '0) ? '0 : quotient;
  assign p1_sum = ibase_r + {3'b000, frac_r[FRAC_W-1:P2_BITS]};

  always_comb begin
    case (cw.sel)
      SEL_ADDR:   byte_sel = short_r ? ADDR_SHORT : ADDR_FULL;
      SEL_P1_MID: byte_sel = p1_r[15:8];
      SEL_P1_LO:  byte_sel = p1_r[7:0];
      SEL_P2_HI:  byte_sel = {P2_TOP_MARK, frac_r[P2_BITS-1:16]};
      SEL_P2_MID: byte_sel = frac_r[15:8];
      SEL_P2_LO:  byte_sel = frac_r[7:0];
      default:    byte_sel = '0;
    endcase
  end

  // sequencer: hold in wait and emit steps until the handshake allows
  always_comb begin
    hold = 1'b0;
    if (cw.op == OP_WAIT) hold = ~in_tvalid;
    if (cw.op == OP_EMIT) hold = ~slot_free;
    case (cw.cond)
      COND_ALWAYS: take_jump = 1'b1;
      COND_CNT_NZ: take_jump = (cnt_r != '0);
      COND_SHORT:  take_jump = short_r;
      default:     take_jump = 1'b0;
    endcase
    cnt_nxt = cnt_r;
    if (cw.op == OP_MUL) cnt_nxt = CNT_W'(DIV_STEPS - 1);
    if (cw.op == OP_DIV) cnt_nxt = cnt_r - 1'b1;
    if (hold)           pc_nxt = pc_r;
    else if (take_jump) pc_nxt = cw.target;
    else                pc_nxt = pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_WAIT;
      last_mid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.op == OP_P1 && p1_sum[15:8] != last_mid_r) last_mid_r <= p1_sum[15:8];
      if (cw.op == OP_EMIT && slot_free) out_valid_r <= 1'b1;
      else if (out_tready)               out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (cw.op == OP_WAIT && in_tvalid) begin
      neg_r <= in_tdata[OFFSET_W-1];
      mag_r <= in_tdata[OFFSET_W-1] ? (~in_tdata + 1'b1) : in_tdata;
    end
    if (cw.op == OP_FRAC)
      frac_r <= {{(FRAC_W-FBASE_W){1'b0}}, fbase_r} + (neg_r ? (~term + 1'b1) : term);
    if (cw.op == OP_P1) begin
      p1_r    <= p1_sum;
      short_r <= (p1_sum[15:8] == last_mid_r);
    end
    if (cw.op == OP_EMIT && slot_free) begin
      out_data_r  <= byte_sel;
      out_first_r <= cw.first;
      out_last_r  <= cw.last;
      out_short_r <= short_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_short_r, out_first_r};
  assign out_tlast  = out_last_r;

  `PRW_ASSERT(a_accept_starts_mul, (in_tvalid && in_tready) |=> (pc_r == STEP_MUL),
              "accepted request did not start the multiply step")
  `PRW_ASSERT(a_addr_byte, (out_tvalid && out_tuser[0]) |-> (out_tuser[1] ?
              (out_tdata == ADDR_SHORT) : (out_tdata == ADDR_FULL)),
              "address byte does not match write length")
  `PRW_ASSERT_ALWAYS(a_pc_range, $past(!rst_n) |-> (pc_r == STEP_WAIT),
                     "sequencer not in wait step after reset")

endmodule
